FILE: rtl/nmc_pkg.sv
package nmc_pkg;

   localparam int MAX_SIZE_DEFAULT = 8;

   localparam int ELEM_W      = 16;
   localparam int ACC_W       = 64;
   localparam int PROD_W      = 80;
   localparam int CFG_SIZE_W  = 4;
   localparam int CFG_POWER_W = 5;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 5;
   localparam int RSP_DATA_W  = 8;

   localparam logic [CFG_SIZE_W-1:0]  SIZE_RESET  = 4'd3;
   localparam logic [CFG_POWER_W-1:0] POWER_RESET = 5'd10;
   localparam logic [CFG_POWER_W-1:0] POWER_FIRST = 5'd2;
   localparam logic [CFG_POWER_W-1:0] POWER_CAP   = 5'd16;

   localparam logic [CSR_INDEX_W-1:0] REG_MATRIX_SIZE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_POWER   = 1'd1;

   typedef struct packed {
      logic load_we;
      logic test_start;
      logic power_start;
      logic issue;
      logic first;
      logic last;
      logic src_orig;
      logic dest_b;
   } ctl_cmd_type;

   typedef struct packed {
      logic busy;
      logic nonzero;
      logic overflow;
   } dp_sts_type;

endpackage

FILE: rtl/nilpotent_matrix_check.sv
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tdata: element; tlast: last element of the matrix
// rsp      out        rsp_tvalid/rsp_tready  tdata: is_nilpotent, nil_index, overflow
// csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// Elements load at one per cycle while the block waits for a matrix.
// After the last element each power is formed through the single
// multiply-accumulate pipeline, which drains before the power is checked.
// Reset is synchronous; it clears control state, and the matrix stores are not cleared.
// A result waits in an output register; the next matrix may load meanwhile.
module nilpotent_matrix_check #(
   parameter int MAX_SIZE = nmc_pkg::MAX_SIZE_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [nmc_pkg::ELEM_W-1:0]        req_tdata,  // element
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [nmc_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // is_nilpotent, nil_index, overflow
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [nmc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [nmc_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1;

   nmc_pkg::ctl_cmd_type cmd;
   nmc_pkg::dp_sts_type  sts;
   logic [AW-1:0]        load_addr;
   logic [AW-1:0]        pow_addr;
   logic [AW-1:0]        org_addr;
   logic [AW-1:0]        wr_addr;
   logic                 rsp_nil;
   logic [nmc_pkg::CFG_POWER_W-1:0] rsp_index;
   logic                 rsp_ovf;

   nmc_control #(.MAX_SIZE(MAX_SIZE)) u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_nil    (rsp_nil),
      .rsp_index  (rsp_index),
      .rsp_ovf    (rsp_ovf),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .load_addr  (load_addr),
      .pow_addr   (pow_addr),
      .org_addr   (org_addr),
      .wr_addr    (wr_addr),
      .sts        (sts)
   );

   nmc_datapath #(.MAX_SIZE(MAX_SIZE)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .load_addr (load_addr),
      .load_data (req_tdata),
      .pow_addr  (pow_addr),
      .org_addr  (org_addr),
      .wr_addr   (wr_addr),
      .sts       (sts)
   );

   assign rsp_tdata = {1'b0, rsp_ovf, rsp_index, rsp_nil};

endmodule

FILE: rtl/nmc_ram.sv
module nmc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/nmc_datapath.sv
module nmc_datapath #(
   parameter int MAX_SIZE = nmc_pkg::MAX_SIZE_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  nmc_pkg::ctl_cmd_type      cmd,
   input  logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1)-1:0] load_addr,
   input  logic [nmc_pkg::ELEM_W-1:0] load_data,
   input  logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1)-1:0] pow_addr,
   input  logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1)-1:0] org_addr,
   input  logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1)-1:0] wr_addr,
   output nmc_pkg::dp_sts_type       sts
);

   localparam int CELLS = MAX_SIZE * MAX_SIZE;
   localparam int AW    = (MAX_SIZE > 1) ? $clog2(CELLS) : 1;
   localparam int EW    = nmc_pkg::ELEM_W;
   localparam int DW    = nmc_pkg::ACC_W;
   localparam int PW    = nmc_pkg::PROD_W;

   logic [EW-1:0] orig_k_rdata;
   logic [EW-1:0] orig_p_rdata;
   logic [DW-1:0] pow_a_rdata;
   logic [DW-1:0] pow_b_rdata;

   logic          v1_ff, v2_ff, v3_ff, v4_ff;
   logic          first1_ff, first2_ff, first3_ff;
   logic          last1_ff, last2_ff, last3_ff;
   logic          orig1_ff;
   logic          dest1_ff, dest2_ff, dest3_ff, dest4_ff;
   logic [AW-1:0] wa1_ff, wa2_ff, wa3_ff, wa4_ff;

   logic signed [47:0] pp_hi_ff, pp_hi_in;
   logic signed [48:0] pp_lo_ff, pp_lo_in;
   logic [PW-1:0]      prod_ff, prod_in;
   logic [DW-1:0]      acc_ff, acc_in;
   logic [DW-1:0]      res_ff;
   logic               ovf_ff, ovf_in;
   logic               nonzero_ff, nonzero_in;

   logic [DW-1:0] x_op;
   logic [EW-1:0] y_op;
   logic [DW-1:0] base;
   logic          mul_ovf;
   logic          add_ovf;
   logic          we_a;
   logic          we_b;

   nmc_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_orig_k (
      .clock (clock),
      .we    (cmd.load_we),
      .waddr (load_addr),
      .wdata (load_data),
      .raddr (org_addr),
      .rdata (orig_k_rdata)
   );

   nmc_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_orig_p (
      .clock (clock),
      .we    (cmd.load_we),
      .waddr (load_addr),
      .wdata (load_data),
      .raddr (pow_addr),
      .rdata (orig_p_rdata)
   );

   nmc_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_pow_a (
      .clock (clock),
      .we    (we_a),
      .waddr (wa4_ff),
      .wdata (res_ff),
      .raddr (pow_addr),
      .rdata (pow_a_rdata)
   );

   nmc_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_pow_b (
      .clock (clock),
      .we    (we_b),
      .waddr (wa4_ff),
      .wdata (res_ff),
      .raddr (pow_addr),
      .rdata (pow_b_rdata)
   );

   assign we_a = v4_ff & ~dest4_ff;
   assign we_b = v4_ff & dest4_ff;

   always_comb begin
      if (orig1_ff) begin
         x_op = {{(DW - EW){orig_p_rdata[EW-1]}}, orig_p_rdata};
      end else if (dest1_ff) begin
         x_op = pow_a_rdata;
      end else begin
         x_op = pow_b_rdata;
      end
      y_op = orig_k_rdata;
      pp_hi_in = $signed(x_op[DW-1:32]) * $signed(y_op);
      pp_lo_in = $signed({1'b0, x_op[31:0]}) * $signed(y_op);

      prod_in = {pp_hi_ff, 32'b0} + {{(PW - 49){pp_lo_ff[48]}}, pp_lo_ff};

      mul_ovf = ~(&prod_ff[PW-1:DW-1]) & (|prod_ff[PW-1:DW-1]);
      base    = first3_ff ? '0 : acc_ff;
      acc_in  = base + prod_ff[DW-1:0];
      add_ovf = (base[DW-1] == prod_ff[DW-1]) & (acc_in[DW-1] != base[DW-1]);

      ovf_in = ovf_ff | (v3_ff & (mul_ovf | add_ovf));
      if (cmd.test_start) begin
         ovf_in = 1'b0;
      end
      nonzero_in = nonzero_ff | (v4_ff & (|res_ff));
      if (cmd.power_start) begin
         nonzero_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         v4_ff      <= 1'b0;
         ovf_ff     <= 1'b0;
         nonzero_ff <= 1'b0;
      end else begin
         v1_ff      <= cmd.issue;
         v2_ff      <= v1_ff;
         v3_ff      <= v2_ff;
         v4_ff      <= v3_ff & last3_ff;
         ovf_ff     <= ovf_in;
         nonzero_ff <= nonzero_in;
      end
   end

   always_ff @(posedge clock) begin
      first1_ff <= cmd.first;
      last1_ff  <= cmd.last;
      orig1_ff  <= cmd.src_orig;
      dest1_ff  <= cmd.dest_b;
      wa1_ff    <= wr_addr;
      first2_ff <= first1_ff;
      last2_ff  <= last1_ff;
      dest2_ff  <= dest1_ff;
      wa2_ff    <= wa1_ff;
      pp_hi_ff  <= pp_hi_in;
      pp_lo_ff  <= pp_lo_in;
      first3_ff <= first2_ff;
      last3_ff  <= last2_ff;
      dest3_ff  <= dest2_ff;
      wa3_ff    <= wa2_ff;
      prod_ff   <= prod_in;
      dest4_ff  <= dest3_ff;
      wa4_ff    <= wa3_ff;
      res_ff    <= acc_in;
      if (v3_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign sts.busy     = v1_ff | v2_ff | v3_ff | v4_ff;
   assign sts.nonzero  = nonzero_ff;
   assign sts.overflow = ovf_ff;

endmodule

FILE: rtl/nmc_control.sv
module nmc_control #(
   parameter int MAX_SIZE = nmc_pkg::MAX_SIZE_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic                           rsp_nil,
   output logic [nmc_pkg::CFG_POWER_W-1:0] rsp_index,
   output logic                           rsp_ovf,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [nmc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nmc_pkg::CSR_DATA_W-1:0]  csr_data,
   output nmc_pkg::ctl_cmd_type           cmd,
   output logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1)-1:0] load_addr,
   output logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1)-1:0] pow_addr,
   output logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1)-1:0] org_addr,
   output logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1)-1:0] wr_addr,
   input  nmc_pkg::dp_sts_type            sts
);

   localparam int CELLS  = MAX_SIZE * MAX_SIZE;
   localparam int AW     = (MAX_SIZE > 1) ? $clog2(CELLS) : 1;
   localparam int CW     = $clog2(CELLS + 1);
   localparam int SIZE_W = $clog2(MAX_SIZE + 1);
   localparam int PCW    = nmc_pkg::CFG_POWER_W;

   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]                        state_ff, state_in;
   logic [nmc_pkg::CFG_SIZE_W-1:0]    size_ff, size_in;
   logic [PCW-1:0]                    limit_ff, limit_in;
   logic [CW-1:0]                     load_count_ff, load_count_in;
   logic [PCW-1:0]                    power_ff, power_in;
   logic [SIZE_W-1:0]                 i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [AW-1:0]                     i_base_ff, i_base_in, k_base_ff, k_base_in;
   logic                              nil_ff, nil_in;
   logic [PCW-1:0]                    nil_index_ff, nil_index_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_nil_ff, rsp_nil_in;
   logic [PCW-1:0]                    rsp_index_ff, rsp_index_in;
   logic                              rsp_ovf_ff, rsp_ovf_in;

   logic [SIZE_W-1:0] n_eff;
   logic [SIZE_W-1:0] n_m1;
   logic [PCW-1:0]    lim_eff;
   logic              req_accept;

   always_comb begin
      if (size_ff == '0) begin
         n_eff = SIZE_W'(1);
      end else if (int'(size_ff) > MAX_SIZE) begin
         n_eff = SIZE_W'(MAX_SIZE);
      end else begin
         n_eff = SIZE_W'(size_ff);
      end
      n_m1 = n_eff - SIZE_W'(1);
      if (limit_ff < nmc_pkg::POWER_FIRST) begin
         lim_eff = nmc_pkg::POWER_FIRST;
      end else if (limit_ff > nmc_pkg::POWER_CAP) begin
         lim_eff = nmc_pkg::POWER_CAP;
      end else begin
         lim_eff = limit_ff;
      end
   end

   assign req_tready = (state_ff == ST_LOAD);
   assign req_accept = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      state_in      = state_ff;
      size_in       = size_ff;
      limit_in      = limit_ff;
      load_count_in = load_count_ff;
      power_in      = power_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      i_base_in     = i_base_ff;
      k_base_in     = k_base_ff;
      nil_in        = nil_ff;
      nil_index_in  = nil_index_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_nil_in    = rsp_nil_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      cmd           = '0;

      if (csr_valid) begin
         case (csr_index)
            nmc_pkg::REG_MATRIX_SIZE: size_in = csr_data[nmc_pkg::CFG_SIZE_W-1:0];
            nmc_pkg::REG_MAX_POWER:   limit_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               if (load_count_ff < CW'(CELLS)) begin
                  cmd.load_we   = 1'b1;
                  load_count_in = load_count_ff + CW'(1);
               end
               if (req_tlast) begin
                  cmd.test_start  = 1'b1;
                  cmd.power_start = 1'b1;
                  power_in        = nmc_pkg::POWER_FIRST;
                  i_in            = '0;
                  j_in            = '0;
                  k_in            = '0;
                  i_base_in       = '0;
                  k_base_in       = '0;
                  state_in        = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            cmd.issue    = 1'b1;
            cmd.first    = (k_ff == '0);
            cmd.last     = (k_ff == n_m1);
            cmd.src_orig = (power_ff == nmc_pkg::POWER_FIRST);
            cmd.dest_b   = power_ff[0];
            if (k_ff == n_m1) begin
               k_in      = '0;
               k_base_in = '0;
               if (j_ff == n_m1) begin
                  j_in = '0;
                  if (i_ff == n_m1) begin
                     state_in = ST_DRAIN;
                  end else begin
                     i_in      = i_ff + SIZE_W'(1);
                     i_base_in = i_base_ff + AW'(n_eff);
                  end
               end else begin
                  j_in = j_ff + SIZE_W'(1);
               end
            end else begin
               k_in      = k_ff + SIZE_W'(1);
               k_base_in = k_base_ff + AW'(n_eff);
            end
         end
         ST_DRAIN: begin
            if (!sts.busy) begin
               if (!sts.nonzero) begin
                  nil_in       = 1'b1;
                  nil_index_in = power_ff;
                  state_in     = ST_DONE;
               end else if (power_ff >= lim_eff) begin
                  nil_in       = 1'b0;
                  nil_index_in = '0;
                  state_in     = ST_DONE;
               end else begin
                  cmd.power_start = 1'b1;
                  power_in        = power_ff + PCW'(1);
                  i_in            = '0;
                  j_in            = '0;
                  k_in            = '0;
                  i_base_in       = '0;
                  k_base_in       = '0;
                  state_in        = ST_ISSUE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_nil_in    = nil_ff;
               rsp_index_in  = nil_index_ff;
               rsp_ovf_in    = sts.overflow;
               load_count_in = '0;
               state_in      = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         size_ff       <= nmc_pkg::SIZE_RESET;
         limit_ff      <= nmc_pkg::POWER_RESET;
         load_count_ff <= '0;
         power_ff      <= nmc_pkg::POWER_FIRST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         size_ff       <= size_in;
         limit_ff      <= limit_in;
         load_count_ff <= load_count_in;
         power_ff      <= power_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      i_base_ff    <= i_base_in;
      k_base_ff    <= k_base_in;
      nil_ff       <= nil_in;
      nil_index_ff <= nil_index_in;
      rsp_nil_ff   <= rsp_nil_in;
      rsp_index_ff <= rsp_index_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign pow_addr   = i_base_ff + AW'(k_ff);
   assign org_addr   = k_base_ff + AW'(j_ff);
   assign wr_addr    = i_base_ff + AW'(j_ff);
   assign load_addr  = load_count_ff[AW-1:0];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_nil    = rsp_nil_ff;
   assign rsp_index  = rsp_index_ff;
   assign rsp_ovf    = rsp_ovf_ff;

endmodule
